>>> rtl/core/usb_port_protection_controller_macros.svh
// ----------------------------------------------------------------------------
// USB port protection controller assertion macros
// Concurrent assertion wrappers clocked on clk_i, with and without the
// reset qualifier. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef USB_PORT_PROTECTION_CONTROLLER_MACROS_SVH
`define USB_PORT_PROTECTION_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside of reset
`define UPPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every rising edge, reset included
`define UPPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define UPPC_ASSERT(label, prop, msg)
`define UPPC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/core/uppc_pkg.sv
// ----------------------------------------------------------------------------
// USB port protection controller package
// Mode, event, op and register codes plus field widths of the stream items.
// ----------------------------------------------------------------------------
`default_nettype none

package uppc_pkg;

  // Field widths
  localparam int unsigned FbW      = 12;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned IdleW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 8;

  localparam logic [IdleW-1:0] IdleLimitRst = 32'd259200;
  localparam logic [HoldW-1:0] FaultTimerMax = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_OFF        = 2'd0,
    MODE_ON         = 2'd1,
    MODE_FAULT      = 2'd2,
    MODE_MANUAL_OFF = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_ON    = 3'd1,
    EV_SHORT = 3'd2,
    EV_FUEL  = 3'd3,
    EV_IDLE  = 3'd4
  } event_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_SHORT_THRESHOLD = 2'd0,
    CFG_FAULT_HOLD      = 2'd1,
    CFG_IDLE_LIMIT      = 2'd2
  } cfg_reg_e;

  // One input item as held in the input register
  typedef struct packed {
    op_e              op;
    logic [FbW-1:0]   usb_feedback;
    logic             fuel_bad;
    logic [IdleW-1:0] idle_time;
    mode_e            new_mode;
  } in_item_t;

  // One result item as held in the result register
  typedef struct packed {
    event_e event_res;
    mode_e  mode;
    logic   port_enable;
  } res_item_t;

endpackage

`default_nettype wire

>>> rtl/core/usb_port_protection_controller.sv
// ----------------------------------------------------------------------------
// USB port protection controller
// Mode control of a 5 V output port with short, fuel, credit and idle checks.
// ----------------------------------------------------------------------------
// Each input transfer is one tick or one forced mode change and yields exactly
// one result transfer. An item passes an input register, one short block of
// compare and counter logic, and a result register, which offers the result
// until it transfers. A new item is taken in every cycle while the result
// side keeps up; a stalled result holds the input register, and input ready
// drops once both are full. The mode, port, short counter and fault timer
// update when an item moves into the result register, so items see the
// state in strict arrival order. Configuration writes are always ready;
// write them only while no item is in flight.
`default_nettype none

`include "usb_port_protection_controller_macros.svh"

module usb_port_protection_controller #(
  parameter int unsigned SHORT_TICKS = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [uppc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [uppc_pkg::CfgDataW-1:0] cfg_data_i,
  // Input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // usb_feedback[11:0], low_fuel[12], empty_fuel[13], credit_disabled[14],
  // idle_time[46:15], new_mode[48:47], zero[55:49]
  input  wire logic [uppc_pkg::InDataW-1:0]  s_axis_tdata,
  // op[0]
  input  wire logic                          s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // port_enable[0], mode[2:1], event_res[5:3], zero[7:6]
  output logic [uppc_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned ScW = $clog2(SHORT_TICKS + 2);
  localparam logic [ScW-1:0] ShortLimit = ScW'(SHORT_TICKS);

  // Configuration registers
  logic [uppc_pkg::FbW-1:0]   short_threshold_q;
  logic [uppc_pkg::HoldW-1:0] fault_hold_q;
  logic [uppc_pkg::IdleW-1:0] idle_limit_q;

  // Stage registers
  logic                 in_valid_q;
  uppc_pkg::in_item_t   in_q;
  logic                 res_valid_q;
  uppc_pkg::res_item_t  res_q, res_d;
  logic                 advance;

  // Controller state
  uppc_pkg::mode_e            mode_q, mode_d;
  logic                       port_on_q, port_on_d;
  logic [ScW-1:0]             short_count_q, short_count_d;
  logic [uppc_pkg::HoldW-1:0] fault_timer_q, fault_timer_d;

  // Shared tick conditions
  logic                       is_tick;
  logic                       below_thr;
  logic [ScW-1:0]             short_inc;
  logic                       short_hit;
  logic                       idle_over;
  logic                       off_clear;
  logic [uppc_pkg::HoldW-1:0] timer_inc;
  logic                       hold_done;

  // Accept writes at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_threshold_q <= '0;
      fault_hold_q      <= '0;
      idle_limit_q      <= uppc_pkg::IdleLimitRst;
    end else if (cfg_valid_i) begin
      unique case (uppc_pkg::cfg_reg_e'(cfg_index_i))
        uppc_pkg::CFG_SHORT_THRESHOLD: short_threshold_q <= cfg_data_i[uppc_pkg::FbW-1:0];
        uppc_pkg::CFG_FAULT_HOLD:      fault_hold_q      <= cfg_data_i[uppc_pkg::HoldW-1:0];
        uppc_pkg::CFG_IDLE_LIMIT:      idle_limit_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Move the input stage forward whenever the result register is free
  assign advance       = !res_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  // Capture the input transfer, merging the three off flags
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.op           <= uppc_pkg::op_e'(s_axis_tuser);
      in_q.usb_feedback <= s_axis_tdata[11:0];
      in_q.fuel_bad     <= s_axis_tdata[12] | s_axis_tdata[13] | s_axis_tdata[14];
      in_q.idle_time    <= s_axis_tdata[46:15];
      in_q.new_mode     <= uppc_pkg::mode_e'(s_axis_tdata[48:47]);
    end
  end

  // Tick conditions
  assign is_tick   = (in_q.op == uppc_pkg::OP_TICK);
  assign below_thr = (in_q.usb_feedback < short_threshold_q);
  assign short_inc = short_count_q + ScW'(1);
  assign short_hit = below_thr && (short_inc > ShortLimit);
  assign idle_over = (in_q.idle_time >= idle_limit_q);
  assign off_clear = !idle_over && !in_q.fuel_bad;
  assign timer_inc = (fault_timer_q != uppc_pkg::FaultTimerMax) ?
                     fault_timer_q + uppc_pkg::HoldW'(1) : fault_timer_q;
  assign hold_done = (timer_inc >= fault_hold_q);

  // Next mode
  always_comb begin
    mode_d = mode_q;
    if (!is_tick) begin
      mode_d = in_q.new_mode;
    end else begin
      unique case (mode_q)
        uppc_pkg::MODE_OFF: begin
          if (off_clear) mode_d = uppc_pkg::MODE_ON;
        end
        uppc_pkg::MODE_FAULT: begin
          if (hold_done) mode_d = uppc_pkg::MODE_OFF;
        end
        uppc_pkg::MODE_ON: begin
          if (short_hit) begin
            mode_d = uppc_pkg::MODE_FAULT;
          end else if (in_q.fuel_bad || idle_over) begin
            mode_d = uppc_pkg::MODE_OFF;
          end
        end
        default: ;
      endcase
    end
  end

  // Port, counters and event
  always_comb begin
    port_on_d       = port_on_q;
    short_count_d   = short_count_q;
    fault_timer_d   = fault_timer_q;
    res_d.event_res = uppc_pkg::EV_NONE;
    if (is_tick) begin
      unique case (mode_q)
        uppc_pkg::MODE_OFF: begin
          if (off_clear) begin
            port_on_d       = 1'b1;
            res_d.event_res = uppc_pkg::EV_ON;
          end
        end
        uppc_pkg::MODE_MANUAL_OFF: begin
          port_on_d = 1'b0;
        end
        uppc_pkg::MODE_FAULT: begin
          fault_timer_d = timer_inc;
        end
        default: begin
          short_count_d = below_thr ? short_inc : '0;
          if (short_hit) begin
            short_count_d   = '0;
            port_on_d       = 1'b0;
            fault_timer_d   = '0;
            res_d.event_res = uppc_pkg::EV_SHORT;
          end else if (in_q.fuel_bad) begin
            port_on_d       = 1'b0;
            res_d.event_res = uppc_pkg::EV_FUEL;
          end else if (idle_over) begin
            port_on_d       = 1'b0;
            res_d.event_res = uppc_pkg::EV_IDLE;
          end else begin
            port_on_d = 1'b1;
          end
        end
      endcase
    end
    res_d.mode        = mode_d;
    res_d.port_enable = port_on_d;
  end

  // Commit state as the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= uppc_pkg::MODE_ON;
      port_on_q     <= 1'b0;
      short_count_q <= '0;
      fault_timer_q <= '0;
    end else if (advance && in_valid_q) begin
      mode_q        <= mode_d;
      port_on_q     <= port_on_d;
      short_count_q <= short_count_d;
      fault_timer_q <= fault_timer_d;
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.event_res, res_q.mode, res_q.port_enable};

  // Checks
  `UPPC_ASSERT(short_count_bound_a, short_count_q <= ShortLimit, "short counter above limit")
  `UPPC_ASSERT(short_event_off_a,
    res_valid_q && res_q.event_res == uppc_pkg::EV_SHORT |->
      res_q.mode == uppc_pkg::MODE_FAULT && !res_q.port_enable,
    "short event without fault mode and port off")
  `UPPC_ASSERT(on_event_on_a,
    advance && in_valid_q && res_d.event_res == uppc_pkg::EV_ON |->
      res_d.mode == uppc_pkg::MODE_ON && res_d.port_enable && mode_q == uppc_pkg::MODE_OFF,
    "turn-on event not from off mode")
  `UPPC_ASSERT(commit_tracks_result_a,
    advance && in_valid_q |=>
      res_valid_q && mode_q == res_q.mode && port_on_q == res_q.port_enable,
    "state and result register out of step")

endmodule

`default_nettype wire

>>> bench/usb_port_protection_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// USB port protection controller regression
// Drives tick and set-mode items into the input stream and checks every
// result transfer against an in-bench prediction of the port mode, enable
// and event. A short directed table comes first. A fault timer soak follows,
// then random phases with varied register settings and flow-control idling.
// ----------------------------------------------------------------------------
module usb_port_protection_controller_test;
  import uppc_pkg::*;

  localparam int unsigned ShortTicks        = 5;
  localparam int unsigned CycleLimit        = 1_000_000;
  localparam int unsigned NumPhases         = 8;
  localparam int unsigned RandItemsPerPhase = 175;
  localparam int unsigned DrainCycles       = 8;
  localparam int unsigned InPadW            = InDataW - 2 - IdleW - 3 - FbW;

  // Register index outside the map; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  // Fuel and credit flags of a tick, {credit_disabled, empty_fuel, low_fuel}
  localparam logic [2:0] NoFlags   = 3'b000;
  localparam logic [2:0] LowFuel   = 3'b001;
  localparam logic [2:0] EmptyFuel = 3'b010;
  localparam logic [2:0] CreditOff = 3'b100;
  localparam logic [2:0] AllFlags  = 3'b111;

  typedef struct packed {
    op_e              op;
    logic [FbW-1:0]   usb_feedback;
    logic             low_fuel;
    logic             empty_fuel;
    logic             credit_disabled;
    logic [IdleW-1:0] idle_time;
    mode_e            new_mode;
  } port_item_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    port_item_t          item;
    logic                has_want;
    res_item_t           want;
  } plan_row_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic                s_axis_tuser   = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // Predicted register settings and port state
  logic [FbW-1:0]   thr_q;
  logic [HoldW-1:0] hold_q;
  logic [IdleW-1:0] lim_q;
  mode_e            mode_q;
  logic             port_q;
  int unsigned      short_cnt;
  logic [HoldW-1:0] tmr_q;

  res_item_t   port_reports_q[$];
  plan_row_t   plan_q[$];
  int unsigned src_gap_pct     = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned short_run_left  = 0;
  int unsigned cycle_count     = 0;
  int          error_count     = 0;

  usb_port_protection_controller #(
    .SHORT_TICKS(ShortTicks)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Advance the port state by one item and return the report it produces
  function automatic res_item_t next_port_report(input port_item_t it);
    logic      fuel_bad;
    event_e    ev;
    res_item_t r;
    fuel_bad = it.low_fuel | it.empty_fuel | it.credit_disabled;
    ev = EV_NONE;
    if (it.op == OP_SET) begin
      mode_q = it.new_mode;
    end else begin
      case (mode_q)
        MODE_OFF: begin
          if (it.idle_time < lim_q && !fuel_bad) begin
            mode_q = MODE_ON;
            port_q = 1'b1;
            ev = EV_ON;
          end
        end
        MODE_MANUAL_OFF: begin
          port_q = 1'b0;
        end
        MODE_FAULT: begin
          if (tmr_q != FaultTimerMax) tmr_q = tmr_q + 1'b1;
          if (tmr_q >= hold_q) mode_q = MODE_OFF;
        end
        default: begin
          if (it.usb_feedback < thr_q) short_cnt++;
          else short_cnt = 0;
          // A latched short ends the tick: no fuel or idle check
          if (short_cnt > ShortTicks) begin
            short_cnt = 0;
            port_q = 1'b0;
            mode_q = MODE_FAULT;
            tmr_q = '0;
            ev = EV_SHORT;
          end else if (fuel_bad) begin
            mode_q = MODE_OFF;
            port_q = 1'b0;
            ev = EV_FUEL;
          end else if (it.idle_time >= lim_q) begin
            mode_q = MODE_OFF;
            port_q = 1'b0;
            ev = EV_IDLE;
          end else begin
            port_q = 1'b1;
          end
        end
      endcase
    end
    r.port_enable = port_q;
    r.mode = mode_q;
    r.event_res = ev;
    return r;
  endfunction

  function automatic port_item_t mk_tick(input logic [FbW-1:0] fb, input logic [2:0] flags,
                                         input logic [IdleW-1:0] idle);
    port_item_t it;
    it.op = OP_TICK;
    it.usb_feedback = fb;
    {it.credit_disabled, it.empty_fuel, it.low_fuel} = flags;
    it.idle_time = idle;
    it.new_mode = mode_e'($urandom_range(3, 0));
    return it;
  endfunction

  function automatic port_item_t mk_set(input mode_e m);
    port_item_t it;
    it.op = OP_SET;
    it.usb_feedback = 12'($urandom);
    {it.credit_disabled, it.empty_fuel, it.low_fuel} = 3'($urandom);
    it.idle_time = $urandom;
    it.new_mode = m;
    return it;
  endfunction

  function automatic res_item_t mk_report(input logic pe, input mode_e m, input event_e e);
    res_item_t r;
    r.port_enable = pe;
    r.mode = m;
    r.event_res = e;
    return r;
  endfunction

  // Random item: mostly healthy ticks, bursts of shorted feedback, rare flags
  function automatic port_item_t make_random_item();
    port_item_t  it;
    int unsigned roll;
    it.op = ($urandom_range(99, 0) < 6) ? OP_SET : OP_TICK;
    it.new_mode = mode_e'($urandom_range(3, 0));
    if (short_run_left == 0 && $urandom_range(99, 0) < 12) short_run_left = $urandom_range(9, 3);
    if (short_run_left != 0 && thr_q != 0) it.usb_feedback = 12'($urandom_range(thr_q - 1, 0));
    else if ($urandom_range(99, 0) < 70) it.usb_feedback = 12'($urandom_range(4095, thr_q));
    else it.usb_feedback = 12'($urandom);
    if (short_run_left != 0) short_run_left--;
    it.low_fuel = ($urandom_range(99, 0) < 4);
    it.empty_fuel = ($urandom_range(99, 0) < 4);
    it.credit_disabled = ($urandom_range(99, 0) < 4);
    roll = $urandom_range(99, 0);
    if (roll < 5) it.idle_time = $urandom;
    else if (roll < 85 && lim_q != 0) it.idle_time = $urandom_range(lim_q - 1, 0);
    else it.idle_time = $urandom_range(32'hFFFF_FFFF, lim_q);
    return it;
  endfunction

  task automatic plan_item(input port_item_t it);
    plan_row_t row;
    row = '0;
    row.item = it;
    plan_q.push_back(row);
  endtask

  task automatic plan_check(input port_item_t it, input logic pe, input mode_e m,
                            input event_e e);
    plan_row_t row;
    row = '0;
    row.item = it;
    row.has_want = 1'b1;
    row.want = mk_report(pe, m, e);
    plan_q.push_back(row);
  endtask

  task automatic plan_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan_q.push_back(row);
  endtask

  // Offer one item, hold it until the transfer, then queue its report
  task automatic drive_item(input port_item_t it, input logic has_want, input res_item_t want);
    res_item_t pred;
    while ($urandom_range(99, 0) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {{InPadW{1'b0}}, it.new_mode, it.idle_time, it.credit_disabled,
                     it.empty_fuel, it.low_fuel, it.usb_feedback};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = next_port_report(it);
    port_reports_q.push_back(has_want ? want : pred);
  endtask

  // Drop valid and wait until every queued report has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (port_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_SHORT_THRESHOLD: thr_q = val[FbW-1:0];
      CFG_FAULT_HOLD:      hold_q = val[HoldW-1:0];
      CFG_IDLE_LIMIT:      lim_q = val[IdleW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [FbW-1:0] thr, input logic [HoldW-1:0] hold,
                            input logic [IdleW-1:0] lim);
    drain();
    write_reg(CFG_SHORT_THRESHOLD, CfgDataW'(thr));
    write_reg(CFG_FAULT_HOLD, CfgDataW'(hold));
    write_reg(CFG_IDLE_LIMIT, lim);
  endtask

  task automatic check_field(input string name, input logic [2:0] want_v,
                             input logic [2:0] seen_v);
    if (seen_v !== want_v) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, seen_v);
    end
  endtask

  // Compare each result transfer with the oldest queued report; stall at random
  always @(posedge clk_i) begin : check_results
    res_item_t seen;
    res_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = res_item_t'(m_axis_tdata[$bits(res_item_t)-1:0]);
      if (port_reports_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual port %0d mode %0d event %0d",
                 $time, seen.port_enable, seen.mode, seen.event_res);
      end else begin
        want = port_reports_q.pop_front();
        check_field("port_enable", 3'(want.port_enable), 3'(seen.port_enable));
        check_field("mode", 3'(want.mode), 3'(seen.mode));
        check_field("event_res", want.event_res, seen.event_res);
      end
    end
    m_axis_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("usb_port_protection_controller regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    thr_q = '0;
    hold_q = '0;
    lim_q = IdleLimitRst;
    mode_q = MODE_ON;
    port_q = 1'b0;
    short_cnt = 0;
    tmr_q = '0;

    // Reset values: threshold 0, hold 0, idle limit at its default
    plan_check(mk_tick(12'd0, NoFlags, 32'd0), 1'b1, MODE_ON, EV_NONE);
    plan_check(mk_tick(12'd4095, NoFlags, IdleLimitRst), 1'b0, MODE_OFF, EV_IDLE);
    plan_check(mk_tick(12'd4095, NoFlags, 32'd0), 1'b1, MODE_ON, EV_ON);
    plan_check(mk_tick(12'd4095, LowFuel, 32'd0), 1'b0, MODE_OFF, EV_FUEL);
    plan_check(mk_tick(12'd4095, EmptyFuel, 32'd0), 1'b0, MODE_OFF, EV_NONE);
    plan_check(mk_tick(12'd4095, CreditOff, 32'd0), 1'b0, MODE_OFF, EV_NONE);
    plan_check(mk_tick(12'd4095, NoFlags, 32'hFFFF_FFFF), 1'b0, MODE_OFF, EV_NONE);
    plan_check(mk_tick(12'd4095, NoFlags, IdleLimitRst - 1), 1'b1, MODE_ON, EV_ON);
    plan_check(mk_tick(12'd4095, CreditOff, 32'd0), 1'b0, MODE_OFF, EV_FUEL);
    plan_check(mk_tick(12'd4095, NoFlags, 32'd0), 1'b1, MODE_ON, EV_ON);
    // Forced modes leave the port drive as it was
    plan_check(mk_set(MODE_MANUAL_OFF), 1'b1, MODE_MANUAL_OFF, EV_NONE);
    plan_check(mk_tick(12'd4095, NoFlags, 32'd0), 1'b0, MODE_MANUAL_OFF, EV_NONE);
    plan_check(mk_set(MODE_FAULT), 1'b0, MODE_FAULT, EV_NONE);
    plan_check(mk_tick(12'd4095, NoFlags, 32'd0), 1'b0, MODE_OFF, EV_NONE);
    plan_check(mk_set(MODE_ON), 1'b0, MODE_ON, EV_NONE);
    plan_cfg(CFG_SHORT_THRESHOLD, 32'd4095);
    plan_cfg(CFG_FAULT_HOLD, 32'd2);
    plan_cfg(CFG_IDLE_LIMIT, 32'hFFFF_FFFF);
    plan_cfg(CfgUnmapped, 32'h0000_0ABC);
    // Shorted feedback: the sixth tick latches, ignoring all flags
    for (n = 0; n < ShortTicks; n++) plan_item(mk_tick(12'd0, NoFlags, 32'd0));
    plan_check(mk_tick(12'd0, AllFlags, 32'hFFFF_FFFF), 1'b0, MODE_FAULT, EV_SHORT);
    plan_item(mk_tick(12'd0, NoFlags, 32'd0));
    plan_item(mk_tick(12'd0, NoFlags, 32'd0));
    // Forced fault keeps counting from the old timer value
    plan_item(mk_set(MODE_FAULT));
    plan_item(mk_tick(12'd0, NoFlags, 32'd0));
    plan_item(mk_tick(12'd4095, NoFlags, 32'hFFFF_FFFE));
    plan_item(mk_tick(12'd4094, LowFuel, 32'd0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        drain();
        write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
      end else begin
        drive_item(plan_q[i].item, plan_q[i].has_want, plan_q[i].want);
      end
    end

    // Hold in fault over a longer count, then force fault once more
    set_config(12'd0, 16'd40, 32'hFFFF_FFFF);
    drive_item(mk_set(MODE_FAULT), 1'b0, '0);
    do begin
      drive_item(mk_tick(12'(($urandom)), NoFlags, 32'd0), 1'b0, '0);
    end while (mode_q == MODE_FAULT);
    drive_item(mk_set(MODE_FAULT), 1'b0, '0);
    drive_item(mk_tick(12'd4095, NoFlags, 32'd0), 1'b0, '0);

    // Random phases with varied settings and flow-control idling
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0:       set_config(12'd2048, 16'd3, 32'd100000);
        1:       set_config(12'd4095, 16'd0, 32'hFFFF_FFFF);
        2:       set_config(12'd1, FaultTimerMax, 32'd0);
        3:       set_config(12'd0, 16'd1, 32'd1);
        default: set_config(12'($urandom_range(4095, 1)), 16'($urandom_range(8, 0)), $urandom);
      endcase
      case (p % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 63; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 63; end
        default: begin src_gap_pct = 25; sink_stall_pct = 25; end
      endcase
      short_run_left = 0;
      for (n = 0; n < RandItemsPerPhase; n++) drive_item(make_random_item(), 1'b0, '0);
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("usb_port_protection_controller regression: pass");
    end else begin
      $display("usb_port_protection_controller regression: fail");
    end
    $finish;
  end

endmodule
